// ===== src/gma_pkg.sv =====
// ----------------------------------------------------------------------------
// gma_pkg
// shared constants, widths and handshake structs of the gated moving average
// ----------------------------------------------------------------------------
package gma_pkg;

  // window geometry
  localparam int WINDOW_DEPTH = 10;
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);

  // sample and accumulator widths
  localparam int DATA_W = 16;
  localparam int SUM_W  = DATA_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W + 1);

  // configuration port
  localparam int ADDR_W  = 3;
  localparam int PDATA_W = 32;
  localparam logic [ADDR_W-1:0] REG_UPPER_ADDR = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LOWER_ADDR = 3'd4;
  localparam logic signed [DATA_W-1:0] UPPER_RESET = 16'sd10000;
  localparam logic signed [DATA_W-1:0] LOWER_RESET = -16'sd4000;

  // controller to datapath commands
  typedef struct packed {
    logic accept;    // capture sample, decide reject
    logic update;    // update ring, sum, pointers
    logic div_load;  // load divider from sum and fill count
    logic div_step;  // one quotient bit
    logic out_load;  // load result register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic bypass;    // rejected with empty ring, result is the sample
    logic div_done;  // all quotient bits produced
    logic out_free;  // result register can take a new item
  } sts_t;

endpackage

// ===== src/gma_ctrl.sv =====
// ----------------------------------------------------------------------------
// gma_ctrl
// sequencing state machine: accept, update, divide, deliver
// ----------------------------------------------------------------------------
module gma_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  gma_pkg::sts_t sts,
  output gma_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_UPDATE = 3'd1;
  localparam logic [2:0] S_LOAD   = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  logic [2:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        // rejected with nothing stored: no mean to compute
        state_nxt  = sts.bypass ? S_DONE : S_LOAD;
      end
      S_LOAD: begin
        cmd.div_load = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/gma_datapath.sv =====
// ----------------------------------------------------------------------------
// gma_datapath
// range gate, sample ring, running sum, serial divider and result register
// ----------------------------------------------------------------------------
module gma_datapath (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gma_pkg::cmd_t                         cmd,
  output gma_pkg::sts_t                         sts,
  input  logic signed [gma_pkg::DATA_W-1:0]     upper_limit,
  input  logic signed [gma_pkg::DATA_W-1:0]     lower_limit,
  input  logic signed [gma_pkg::DATA_W-1:0]     in_sample_value,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gma_pkg::DATA_W-1:0]     out_filtered_value,
  output logic                                  out_sample_rejected
);

  localparam int DW = gma_pkg::DATA_W;
  localparam int SW = gma_pkg::SUM_W;
  localparam int CW = gma_pkg::CNT_W;
  localparam int IW = gma_pkg::IDX_W;

  // ring storage, no reset: a slot is read only after it was written
  logic signed [DW-1:0] ring_mem [gma_pkg::WINDOW_DEPTH];
  logic signed [DW-1:0] rd_data_r;

  logic signed [DW-1:0] sample_r;
  logic                 rej_r;
  logic [IW-1:0]        wp_r, wp_nxt;
  logic [CW-1:0]        fill_r, fill_nxt;
  logic signed [SW-1:0] sum_r, sum_nxt;
  logic                 full;
  logic                 wr_en;

  // divider
  logic [SW-1:0]        quo_r, quo_nxt;
  logic [CW-1:0]        rem_r, rem_nxt;
  logic [CW-1:0]        div_r;
  logic                 neg_r;
  logic [gma_pkg::STEP_W-1:0] step_r;
  logic [CW:0]          trial;
  logic [CW:0]          diff;
  logic                 ge;
  logic [SW-1:0]        quo_signed;

  logic                 out_valid_r;
  logic signed [DW-1:0] out_value_r;
  logic                 out_rej_r;

  assign full  = (fill_r == CW'(gma_pkg::WINDOW_DEPTH));
  assign wr_en = cmd.update && !rej_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[wp_r] <= sample_r;
    end
    rd_data_r <= ring_mem[wp_r];
  end

  // sample capture and gate
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sample_r <= in_sample_value;
      rej_r    <= (in_sample_value > upper_limit) || (in_sample_value < lower_limit);
    end
  end

  always_comb begin
    sum_nxt = sum_r + {{(SW-DW){sample_r[DW-1]}}, sample_r};
    if (full) begin
      sum_nxt = sum_nxt - {{(SW-DW){rd_data_r[DW-1]}}, rd_data_r};
    end
    wp_nxt   = (wp_r == IW'(gma_pkg::WINDOW_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    fill_nxt = full ? fill_r : fill_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= '0;
      fill_r <= '0;
      sum_r  <= '0;
    end else if (wr_en) begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
      sum_r  <= sum_nxt;
    end
  end

  // restoring divide of |sum| by the fill count, one bit a cycle
  assign trial   = {rem_r, quo_r[SW-1]};
  assign diff    = trial - {1'b0, div_r};
  assign ge      = (trial >= {1'b0, div_r});
  assign rem_nxt = ge ? diff[CW-1:0] : trial[CW-1:0];
  assign quo_nxt = {quo_r[SW-2:0], ge};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      quo_r  <= sum_r[SW-1] ? SW'(-sum_r) : SW'(sum_r);
      neg_r  <= sum_r[SW-1];
      rem_r  <= '0;
      div_r  <= fill_r;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + 1'b1;
    end
  end

  assign quo_signed = neg_r ? (~quo_r + 1'b1) : quo_r;

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_value_r <= sts.bypass ? sample_r : quo_signed[DW-1:0];
      out_rej_r   <= rej_r;
    end
  end

  assign sts.bypass   = rej_r && (fill_r == '0);
  assign sts.div_done = (step_r == gma_pkg::STEP_W'(SW));
  assign sts.out_free = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_filtered_value  = out_value_r;
  assign out_sample_rejected = out_rej_r;

endmodule

// ===== src/gated_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// gated_moving_average_core
// range-gated moving average over a ring of recent sensor samples
// ----------------------------------------------------------------------------
// Each item is a signed 16 bit sample in hundredths of a unit. A sample between
// lower_limit and upper_limit (inclusive) is stored in a 10 slot ring and the
// result is the truncated-toward-zero mean of the stored samples; a sample
// outside the limits is flagged rejected, leaves all state alone, and returns
// the current mean, or the sample itself when nothing is stored yet. Items are
// handled one at a time: the result comes from a serial divider that produces
// one quotient bit a cycle over the 20 bit sum, and the next item is accepted
// only after that result is loaded into the output register, which waits while
// an earlier result there is still stalled. A rejected sample with an empty
// ring skips the divider and goes from the update state to the result.
// A finished result waits in the output register while the next item is
// already accepted. No clearing pass after reset.
// ----------------------------------------------------------------------------
module gated_moving_average_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  // sample input
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [gma_pkg::DATA_W-1:0]     in_sample_value,
  // result output
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [gma_pkg::DATA_W-1:0]     out_filtered_value,
  output logic                                  out_sample_rejected,
  // register port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [gma_pkg::ADDR_W-1:0]            paddr,
  input  logic [gma_pkg::PDATA_W-1:0]           pwdata,
  output logic [gma_pkg::PDATA_W-1:0]           prdata,
  output logic                                  pready
);

  localparam int DW = gma_pkg::DATA_W;

  gma_pkg::cmd_t cmd;
  gma_pkg::sts_t sts;

  logic signed [DW-1:0] upper_limit_r;
  logic signed [DW-1:0] lower_limit_r;
  logic                 reg_wr;
  logic                 sel_lower;

  // register decode: word address bit picks upper or lower limit
  assign pready    = 1'b1;
  assign reg_wr    = psel && penable && pwrite && pready;
  assign sel_lower = (paddr[2] == gma_pkg::REG_LOWER_ADDR[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= gma_pkg::UPPER_RESET;
      lower_limit_r <= gma_pkg::LOWER_RESET;
    end else if (reg_wr) begin
      if (sel_lower) begin
        lower_limit_r <= pwdata[DW-1:0];
      end else begin
        upper_limit_r <= pwdata[DW-1:0];
      end
    end
  end

  // read back sign extended
  always_comb begin
    if (sel_lower) begin
      prdata = {{(gma_pkg::PDATA_W-DW){lower_limit_r[DW-1]}}, lower_limit_r};
    end else begin
      prdata = {{(gma_pkg::PDATA_W-DW){upper_limit_r[DW-1]}}, upper_limit_r};
    end
  end

  // sequencing
  gma_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // gate, ring, sum, divider, result register
  gma_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .upper_limit         (upper_limit_r),
    .lower_limit         (lower_limit_r),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_value  (out_filtered_value),
    .out_sample_rejected (out_sample_rejected)
  );

endmodule

// ===== src/gma_checker.sv =====
// ----------------------------------------------------------------------------
// gma_checker
// port-level checks of the gated moving average, bound to the top level
// ----------------------------------------------------------------------------
module gma_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic signed [gma_pkg::DATA_W-1:0] in_sample_value,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [gma_pkg::DATA_W-1:0] out_filtered_value,
  input logic                              out_sample_rejected
);

  // a waiting result holds until taken
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_filtered_value)
      && $stable(out_sample_rejected))
    else $error("stalled result changed");

  // a stalled item keeps its sample
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_sample_value))
    else $error("stalled item changed");

  // one item in flight: input closes right after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while one is in work");

  // a result never appears in the cycle after an accept
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

  // reset leaves the block empty and open
  assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle after reset");

endmodule

bind gated_moving_average_core gma_checker u_gma_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_sample_value     (in_sample_value),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_filtered_value  (out_filtered_value),
  .out_sample_rejected (out_sample_rejected)
);

// ===== tb/tb_gated_moving_average_core.sv =====
// ----------------------------------------------------------------------------
// tb_gated_moving_average_core
// self-checking bench for the range-gated moving average core
// ----------------------------------------------------------------------------
// A table of directed items comes first. It covers rejection with an empty
// ring, samples on and beyond both limits, the extremes of the sample range,
// ring wrap, limits at their extremes and crossed limits. Random phases follow.
// Each phase programs both limits over the register port, reads them back,
// and then streams mostly in-range samples with some near-limit and noise
// samples. A window model predicts each result no row types in; results are
// checked in order, field by field. Both sides idle at random but in one
// phase, and the receiver holds off once, long enough that the core backs up.
// ----------------------------------------------------------------------------
module tb_gated_moving_average_core;

  localparam int DATA_W       = gma_pkg::DATA_W;
  localparam int WINDOW_DEPTH = gma_pkg::WINDOW_DEPTH;
  localparam int ADDR_W       = gma_pkg::ADDR_W;
  localparam int PDATA_W      = gma_pkg::PDATA_W;

  localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
  localparam int HOLD_AT_RESULT = 130;   // result count that starts the long hold
  localparam int HOLD_CYCLES    = 300;
  localparam int IDLE_SETTLE    = 30;    // a bit more than one item's latency
  localparam int DRAIN_CYCLES   = 40;
  localparam int PHASES         = 5;
  localparam int PHASE_ITEMS    = 76;
  localparam int DIR_ROWS       = 25;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_UPPER, ROW_LOWER} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic signed [31:0] value;         // sample or limit
    logic               has_exp;       // expected result typed into the row
    logic signed [15:0] exp_filtered;
    logic               exp_rejected;
  } dir_row_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] filtered;
    logic                     rejected;
  } filt_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] in_sample_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] out_filtered_value;
  logic                     out_sample_rejected;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [ADDR_W-1:0]        paddr;
  logic [PDATA_W-1:0]       pwdata;
  logic [PDATA_W-1:0]       prdata;
  logic                     pready;

  // window model state, mirrors what the core should hold
  int win_slots [WINDOW_DEPTH];
  int win_pos;
  int win_fill;
  int win_sum;
  int lim_upper;
  int lim_lower;

  filt_result_t expected_results [$];
  dir_row_t     dir_rows [DIR_ROWS];
  int           mismatch_count;
  int           idle_cycles;
  bit           idle_on;     // random gaps on both sides when set

  gated_moving_average_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_sample_value     (in_sample_value),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_filtered_value  (out_filtered_value),
    .out_sample_rejected (out_sample_rejected),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // state after reset: empty ring, default limits
  function automatic void window_reset();
    for (int k = 0; k < WINDOW_DEPTH; k++) win_slots[k] = 0;
    win_pos   = 0;
    win_fill  = 0;
    win_sum   = 0;
    lim_upper = gma_pkg::UPPER_RESET;
    lim_lower = gma_pkg::LOWER_RESET;
  endfunction

  // one sample through the window: gate, store, mean truncated toward zero
  function automatic void filter_step(input logic signed [DATA_W-1:0] s,
                                      output filt_result_t r);
    if (s > lim_upper || s < lim_lower) begin
      // rejected samples leave the window alone
      r.rejected = 1'b1;
      r.filtered = (win_fill > 0) ? DATA_W'(win_sum / win_fill) : s;
    end else begin
      // a full ring drops its oldest slot before taking the new one
      if (win_fill == WINDOW_DEPTH) win_sum -= win_slots[win_pos];
      win_slots[win_pos] = s;
      win_sum += s;
      win_pos = (win_pos + 1) % WINDOW_DEPTH;
      if (win_fill < WINDOW_DEPTH) win_fill++;
      r.rejected = 1'b0;
      r.filtered = DATA_W'(win_sum / win_fill);
    end
  endfunction

  // random sample: mostly inside the window, some at the edges, some noise
  function automatic logic signed [DATA_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6 && lim_lower <= lim_upper)
      return DATA_W'(lim_lower + int'($urandom_range(0, lim_upper - lim_lower)));
    else if (r < 8)
      case ($urandom_range(0, 3))
        0:       return DATA_W'(lim_lower - 1);
        1:       return DATA_W'(lim_lower);
        2:       return DATA_W'(lim_upper);
        default: return DATA_W'(lim_upper + 1);
      endcase
    else
      return DATA_W'($urandom());
  endfunction

  // offer one item, called and returning at a falling edge
  task automatic send_sample(input logic signed [DATA_W-1:0] s, input logic has_exp,
                             input filt_result_t typed_exp);
    int           gap;
    filt_result_t predicted;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        = 1'b1;
    in_sample_value = s;
    do @(posedge clk); while (in_stall);
    filter_step(s, predicted);
    expected_results.push_back(has_exp ? typed_exp : predicted);
    @(negedge clk);
  endtask

  // core drained and quiet, safe for a register write
  task automatic settle_idle();
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  // limit write followed by a read back, upper half of pwdata is noise
  task automatic cfg_write(input logic [ADDR_W-1:0] addr,
                           input logic signed [DATA_W-1:0] value);
    logic [PDATA_W-1:0] rd;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = {16'($urandom()), value};
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    if (rd[DATA_W-1:0] !== value) begin
      $error("readback addr %0d: expected %0d, actual %0d",
             addr, value, $signed(rd[DATA_W-1:0]));
      mismatch_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (addr == gma_pkg::REG_UPPER_ADDR) lim_upper = value;
    else lim_lower = value;
  endtask

  // result side: random stall per item, one long hold, in-order compare
  initial begin
    int           hold;
    int           seen;
    filt_result_t want;
    out_stall = 1'b0;
    seen      = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (seen == HOLD_AT_RESULT) hold = HOLD_CYCLES;
      else hold = idle_on ? $urandom_range(0, 3) : 0;
      if (hold > 0) begin
        out_stall = 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      seen++;
      if (expected_results.size() == 0) begin
        $error("result with nothing expected: filtered_value %0d sample_rejected %0b",
               out_filtered_value, out_sample_rejected);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_filtered_value !== want.filtered) begin
          $error("filtered_value: expected %0d, actual %0d",
                 want.filtered, out_filtered_value);
          mismatch_count++;
        end
        if (out_sample_rejected !== want.rejected) begin
          $error("sample_rejected: expected %0b, actual %0b",
                 want.rejected, out_sample_rejected);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog: any transfer on any port restarts the count
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
          (psel && penable && pready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("FAIL gated_moving_average_core");
    $finish;
  end

  initial begin
    filt_result_t             typed_exp;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] lo;
    int                       lim_a;
    int                       lim_b;

    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_sample_value = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_on         = 1'b1;
    mismatch_count  = 0;
    window_reset();

    // directed items, default limits 10000 / -4000 until rows change them
    dir_rows = '{
      // empty ring: a rejected sample comes straight back
      '{ROW_SAMPLE,  20000, 1'b1,  20000, 1'b1},
      '{ROW_SAMPLE, -32768, 1'b1, -32768, 1'b1},
      '{ROW_SAMPLE,  32767, 1'b1,  32767, 1'b1},
      // samples on the limits are kept
      '{ROW_SAMPLE,  10000, 1'b1,  10000, 1'b0},
      '{ROW_SAMPLE,  -4000, 1'b1,   3000, 1'b0},
      // just outside: rejected, current mean returned
      '{ROW_SAMPLE,  -4001, 1'b1,   3000, 1'b1},
      '{ROW_SAMPLE,  10001, 1'b1,   3000, 1'b1},
      // fill the ring
      '{ROW_SAMPLE,     -1, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,      0, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,      1, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,   9999, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,  -3999, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,  -4000, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,   5555, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,     -2, 1'b0, 0, 1'b0},
      // ring full: oldest slots are overwritten
      '{ROW_SAMPLE,     -3, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,     -7, 1'b0, 0, 1'b0},
      // widest limits, extreme samples kept
      '{ROW_UPPER,   32767, 1'b0, 0, 1'b0},
      '{ROW_LOWER,  -32768, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,  32767, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0, 0, 1'b0},
      // crossed limits reject everything
      '{ROW_UPPER,    -100, 1'b0, 0, 1'b0},
      '{ROW_LOWER,     100, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE,      0, 1'b0, 0, 1'b0},
      '{ROW_SAMPLE, -32768, 1'b0, 0, 1'b0}
    };

    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      case (dir_rows[i].kind)
        ROW_SAMPLE: begin
          typed_exp.filtered = dir_rows[i].exp_filtered;
          typed_exp.rejected = dir_rows[i].exp_rejected;
          send_sample(dir_rows[i].value[DATA_W-1:0], dir_rows[i].has_exp, typed_exp);
        end
        ROW_UPPER: begin
          settle_idle();
          cfg_write(gma_pkg::REG_UPPER_ADDR, dir_rows[i].value[DATA_W-1:0]);
        end
        default: begin
          settle_idle();
          cfg_write(gma_pkg::REG_LOWER_ADDR, dir_rows[i].value[DATA_W-1:0]);
        end
      endcase
    end

    // random phases, each with its own pair of limits
    typed_exp = '0;
    for (int p = 0; p < PHASES; p++) begin
      lim_a = int'($urandom_range(0, 65535)) - 32768;
      lim_b = int'($urandom_range(0, 65535)) - 32768;
      case (p)
        0: begin
          // full range
          up = 16'sd32767;
          lo = -16'sd32768;
        end
        1: begin
          // ordinary window
          up = DATA_W'((lim_a > lim_b) ? lim_a : lim_b);
          lo = DATA_W'((lim_a > lim_b) ? lim_b : lim_a);
        end
        2: begin
          // crossed
          up = DATA_W'((lim_a > lim_b) ? lim_b : lim_a);
          lo = DATA_W'((lim_a > lim_b) ? lim_a : lim_b);
        end
        3: begin
          // back to reset values, no idling in this phase
          up = gma_pkg::UPPER_RESET;
          lo = gma_pkg::LOWER_RESET;
        end
        default: begin
          // single accepted value
          up = DATA_W'($urandom_range(0, 400) - 200);
          lo = up;
        end
      endcase
      settle_idle();
      idle_on = (p != 3);
      cfg_write(gma_pkg::REG_UPPER_ADDR, up);
      cfg_write(gma_pkg::REG_LOWER_ADDR, lo);
      repeat (PHASE_ITEMS) send_sample(pick_sample(), 1'b0, typed_exp);
    end

    // drain, then give the core time to show any stray result
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("PASS gated_moving_average_core");
    else
      $display("FAIL gated_moving_average_core");
    $finish;
  end

endmodule

// ===== files.f =====
src/gma_pkg.sv
src/gma_ctrl.sv
src/gma_datapath.sv
src/gated_moving_average_core.sv
src/gma_checker.sv
tb/tb_gated_moving_average_core.sv
